### rtl/core/kla_pkg.sv
// ----------------------------------------------------------------------------
// kla_pkg: shared types and constants of the keyframe interpolation animator
// Field widths, channel layout, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kla_pkg;

  localparam int unsigned MAX_KEYS_DEF = 16;

  localparam int unsigned VAL_W      = 24;  // signed Q15.8 channel
  localparam int unsigned FRAC_W     = 16;  // unsigned 0.16 fraction
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned STEP_W     = FRAC_W + 1;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SEG_OUT_W  = 4;
  localparam int unsigned CHANNELS   = 9;
  localparam int unsigned KEY_W      = CHANNELS * VAL_W;
  localparam int unsigned MEM_W      = KEY_W + STEP_W;
  localparam int unsigned KC_W       = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COUNT  = 1'b0,
    REG_RUN_ENABLE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_WRITE,
    ST_RD_BASE,
    ST_RD_NEXT,
    ST_CAP_NEXT,
    ST_MUL,
    ST_OUT
  } state_e;

  // channel order: pos x/y/z, rot x/y/z, scale x/y/z
  typedef struct packed {
    logic                              command;
    logic [SLOT_W-1:0]                 key_slot;
    logic [CHANNELS-1:0][VAL_W-1:0]    key_val;
    logic [FRAME_W-1:0]                key_frames;
  } in_item_t;

  typedef struct packed {
    logic [CHANNELS-1:0][VAL_W-1:0]    val;
    logic [SEG_OUT_W-1:0]              segment;
    logic [FRAC_W-1:0]                 fraction;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic div_step;
    logic mem_write;
    logic sel_next_addr;
    logic capture_base;
    logic capture_next;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic slot_ok;
    logic div_done;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/kla_if.sv
// ----------------------------------------------------------------------------
// kla_if: valid/ready channels of the animator
// Input channel carries key writes and ticks, output channel the blended pose.
// ----------------------------------------------------------------------------
`default_nettype none

interface kla_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [kla_pkg::SLOT_W-1:0]          key_slot;
  logic signed [kla_pkg::VAL_W-1:0]    key_pos_x;
  logic signed [kla_pkg::VAL_W-1:0]    key_pos_y;
  logic signed [kla_pkg::VAL_W-1:0]    key_pos_z;
  logic signed [kla_pkg::VAL_W-1:0]    key_rot_x;
  logic signed [kla_pkg::VAL_W-1:0]    key_rot_y;
  logic signed [kla_pkg::VAL_W-1:0]    key_rot_z;
  logic signed [kla_pkg::VAL_W-1:0]    key_scale_x;
  logic signed [kla_pkg::VAL_W-1:0]    key_scale_y;
  logic signed [kla_pkg::VAL_W-1:0]    key_scale_z;
  logic [kla_pkg::FRAME_W-1:0]         key_frames;

  modport source (
    output valid, command, key_slot, key_pos_x, key_pos_y, key_pos_z,
           key_rot_x, key_rot_y, key_rot_z, key_scale_x, key_scale_y,
           key_scale_z, key_frames,
    input  ready
  );
  modport sink (
    input  valid, command, key_slot, key_pos_x, key_pos_y, key_pos_z,
           key_rot_x, key_rot_y, key_rot_z, key_scale_x, key_scale_y,
           key_scale_z, key_frames,
    output ready
  );
endinterface

interface kla_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kla_pkg::VAL_W-1:0]    out_pos_x;
  logic signed [kla_pkg::VAL_W-1:0]    out_pos_y;
  logic signed [kla_pkg::VAL_W-1:0]    out_pos_z;
  logic signed [kla_pkg::VAL_W-1:0]    out_rot_x;
  logic signed [kla_pkg::VAL_W-1:0]    out_rot_y;
  logic signed [kla_pkg::VAL_W-1:0]    out_rot_z;
  logic signed [kla_pkg::VAL_W-1:0]    out_scale_x;
  logic signed [kla_pkg::VAL_W-1:0]    out_scale_y;
  logic signed [kla_pkg::VAL_W-1:0]    out_scale_z;
  logic [kla_pkg::SEG_OUT_W-1:0]       segment;
  logic [kla_pkg::FRAC_W-1:0]          fraction;

  modport source (
    output valid, out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y,
           out_rot_z, out_scale_x, out_scale_y, out_scale_z, segment, fraction,
    input  ready
  );
  modport sink (
    input  valid, out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y,
           out_rot_z, out_scale_x, out_scale_y, out_scale_z, segment, fraction,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/keyframe_lerp_animator.sv
// ----------------------------------------------------------------------------
// keyframe_lerp_animator: keyframe table with linear pose interpolation
// Stores up to MAX_KEYS keys and blends nine channels between them per tick.
// ----------------------------------------------------------------------------
// A write item stores a key and its phase step through the 17-step serial
// reciprocal of the frame count; a tick returns its pose after two reads of
// the single-read key RAM and the shared multiplier walking the nine
// channels one per cycle. One item is in work at a time; a finished pose
// waits in the output register while the next item is taken. Keys inside
// key_count must be written before ticks read them.
`default_nettype none

module keyframe_lerp_animator #(
  parameter int unsigned MAX_KEYS = kla_pkg::MAX_KEYS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kla_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kla_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  kla_in_if.sink                         item_i,
  kla_out_if.source                      result_o
);

  kla_pkg::cmd_t      cmd;
  kla_pkg::sts_t      sts;
  kla_pkg::in_item_t  item;
  kla_pkg::out_item_t res;
  logic               in_ready;
  logic               out_valid;

  assign item.command    = item_i.command;
  assign item.key_slot   = item_i.key_slot;
  assign item.key_val[0] = item_i.key_pos_x;
  assign item.key_val[1] = item_i.key_pos_y;
  assign item.key_val[2] = item_i.key_pos_z;
  assign item.key_val[3] = item_i.key_rot_x;
  assign item.key_val[4] = item_i.key_rot_y;
  assign item.key_val[5] = item_i.key_rot_z;
  assign item.key_val[6] = item_i.key_scale_x;
  assign item.key_val[7] = item_i.key_scale_y;
  assign item.key_val[8] = item_i.key_scale_z;
  assign item.key_frames = item_i.key_frames;

  kla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kla_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .result_o    (res)
  );

  assign item_i.ready         = in_ready;
  assign result_o.valid       = out_valid;
  assign result_o.out_pos_x   = res.val[0];
  assign result_o.out_pos_y   = res.val[1];
  assign result_o.out_pos_z   = res.val[2];
  assign result_o.out_rot_x   = res.val[3];
  assign result_o.out_rot_y   = res.val[4];
  assign result_o.out_rot_z   = res.val[5];
  assign result_o.out_scale_x = res.val[6];
  assign result_o.out_scale_y = res.val[7];
  assign result_o.out_scale_z = res.val[8];
  assign result_o.segment     = res.segment;
  assign result_o.fraction    = res.fraction;

endmodule

`default_nettype wire

### rtl/core/kla_ram.sv
// ----------------------------------------------------------------------------
// kla_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/kla_ctrl.sv
// ----------------------------------------------------------------------------
// kla_ctrl: sequencer of the animator
// Steps a key write through the step divider and a tick through the two key
// reads, the channel multiply loop and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kla_pkg::sts_t sts_i,
  output kla_pkg::cmd_t cmd_o
);

  kla_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kla_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = kla_pkg::ST_DECODE;
      end
      kla_pkg::ST_DECODE: begin
        priority if (sts_i.is_tick) state_d = kla_pkg::ST_RD_BASE;
        else if (sts_i.slot_ok)     state_d = kla_pkg::ST_DIV;
        else                        state_d = kla_pkg::ST_IDLE;
      end
      kla_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = kla_pkg::ST_WRITE;
      end
      kla_pkg::ST_WRITE:    state_d = kla_pkg::ST_IDLE;
      kla_pkg::ST_RD_BASE:  state_d = kla_pkg::ST_RD_NEXT;
      kla_pkg::ST_RD_NEXT:  state_d = kla_pkg::ST_CAP_NEXT;
      kla_pkg::ST_CAP_NEXT: state_d = kla_pkg::ST_MUL;
      kla_pkg::ST_MUL: begin
        if (sts_i.mul_done) state_d = kla_pkg::ST_OUT;
      end
      kla_pkg::ST_OUT: begin
        if (sts_i.out_free) state_d = kla_pkg::ST_IDLE;
      end
      default: state_d = kla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      kla_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.load_item   = in_valid_i;
      end
      kla_pkg::ST_DECODE:   ;
      kla_pkg::ST_DIV:      cmd_o.div_step = 1'b1;
      kla_pkg::ST_WRITE:    cmd_o.mem_write = 1'b1;
      kla_pkg::ST_RD_BASE:  ;
      kla_pkg::ST_RD_NEXT: begin
        cmd_o.sel_next_addr = 1'b1;
        cmd_o.capture_base  = 1'b1;
      end
      kla_pkg::ST_CAP_NEXT: begin
        cmd_o.sel_next_addr = 1'b1;
        cmd_o.capture_next  = 1'b1;
      end
      kla_pkg::ST_MUL:      cmd_o.mul_step = 1'b1;
      kla_pkg::ST_OUT:      cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/kla_datapath.sv
// ----------------------------------------------------------------------------
// kla_datapath: key table, step divider, phase and blend unit
// Holds the registers, the key RAM, a bit-serial reciprocal for the phase
// step, one shared multiplier walked over the nine channels, and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module kla_datapath #(
  parameter int unsigned MAX_KEYS = kla_pkg::MAX_KEYS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kla_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kla_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  kla_pkg::in_item_t                  item_i,
  input  kla_pkg::cmd_t                      cmd_i,
  output kla_pkg::sts_t                      sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output kla_pkg::out_item_t                 result_o
);

  localparam int unsigned SEG_W  = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int unsigned CH_W   = $clog2(kla_pkg::CHANNELS + 1);
  localparam int unsigned DC_W   = $clog2(kla_pkg::STEP_W);
  localparam int unsigned VAL_W  = kla_pkg::VAL_W;
  localparam int unsigned FRAC_W = kla_pkg::FRAC_W;
  localparam int unsigned PROD_W = VAL_W + FRAC_W + 2;

  // configuration
  logic [kla_pkg::KC_W-1:0] key_count_q;
  logic                     run_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q  <= '0;
      run_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (kla_pkg::cfg_reg_e'(cfg_idx_i))
        kla_pkg::REG_KEY_COUNT:  key_count_q  <= cfg_wdata_i[kla_pkg::KC_W-1:0];
        kla_pkg::REG_RUN_ENABLE: run_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // item latch
  kla_pkg::in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
  end

  // tick decision, taken against the phase as it stands at accept
  logic [SEG_W-1:0]  seg_q, use_seg_q, use_seg_d;
  logic [FRAC_W-1:0] frac_q, use_frac_q, use_frac_d;
  logic              zero_q, zero_d, adv_q, adv_d, clr_d;
  logic [CNT_W-1:0]  cnt_eff;
  logic              wrap;

  assign cnt_eff = (32'(key_count_q) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count_q);
  assign wrap    = (32'(seg_q) + 32'd2) > 32'(cnt_eff);

  always_comb begin
    zero_d     = 1'b0;
    adv_d      = 1'b0;
    clr_d      = 1'b0;
    use_seg_d  = '0;
    use_frac_d = '0;
    priority if (cnt_eff == '0) begin
      zero_d = 1'b1;
    end else if (!run_enable_q) begin
      zero_d = 1'b0;
    end else if (cnt_eff < CNT_W'(2) || wrap) begin
      clr_d = 1'b1;
    end else begin
      adv_d      = 1'b1;
      use_seg_d  = seg_q;
      use_frac_d = frac_q;
    end
  end

  logic [kla_pkg::STEP_W-1:0] base_step_q;
  logic [kla_pkg::STEP_W-1:0] total;

  assign total = kla_pkg::STEP_W'(frac_q) + base_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q      <= '0;
      frac_q     <= '0;
      use_seg_q  <= '0;
      use_frac_q <= '0;
      zero_q     <= 1'b0;
      adv_q      <= 1'b0;
    end else if (cmd_i.load_item) begin
      use_seg_q  <= use_seg_d;
      use_frac_q <= use_frac_d;
      zero_q     <= zero_d;
      adv_q      <= adv_d && (item_i.command == kla_pkg::CMD_TICK);
      if (clr_d && item_i.command == kla_pkg::CMD_TICK) begin
        seg_q  <= '0;
        frac_q <= '0;
      end
    end else if (cmd_i.capture_next && adv_q) begin
      // advance by the base key's step; carry moves to the next segment
      seg_q  <= seg_q + SEG_W'(total[FRAC_W]);
      frac_q <= total[FRAC_W-1:0];
    end
  end

  // bit-serial reciprocal: step = floor(2^FRAC_W / frames), MSB first
  logic [kla_pkg::FRAME_W-1:0] rem_q, divisor;
  logic [kla_pkg::FRAME_W:0]   shifted;
  logic [kla_pkg::STEP_W-1:0]  quo_q;
  logic [DC_W-1:0]             div_cnt_q;
  logic                        ge;

  assign divisor = (item_q.key_frames == '0) ? kla_pkg::FRAME_W'(1) : item_q.key_frames;
  assign shifted = {rem_q, (div_cnt_q == '0)};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      rem_q     <= '0;
    end else if (cmd_i.load_item) begin
      div_cnt_q <= '0;
      rem_q     <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DC_W'(1);
      rem_q     <= ge ? kla_pkg::FRAME_W'(shifted - {1'b0, divisor})
                      : shifted[kla_pkg::FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) quo_q <= {quo_q[kla_pkg::STEP_W-2:0], ge};
  end

  // key table
  logic [kla_pkg::MEM_W-1:0] rdata;
  logic [SEG_W-1:0]          raddr;

  assign raddr = cmd_i.sel_next_addr ? use_seg_q + SEG_W'(1) : use_seg_q;

  kla_ram #(
    .WIDTH (kla_pkg::MEM_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_write),
    .waddr_i (SEG_W'(item_q.key_slot)),
    .wdata_i ({quo_q, item_q.key_val}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [kla_pkg::CHANNELS-1:0][VAL_W-1:0] base_q, next_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_base) {base_step_q, base_q} <= rdata;
    if (cmd_i.capture_next) next_q <= rdata[kla_pkg::KEY_W-1:0];
  end

  // blend loop: multiply channel ch, finish channel ch-1
  logic [CH_W-1:0]            ch_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d, prod_sh;
  logic signed [VAL_W:0]      diff;
  logic signed [FRAC_W:0]     frac_s;
  logic [VAL_W-1:0]           pbase_q;
  logic [kla_pkg::CHANNELS-1:0][VAL_W-1:0] res_q;

  always_comb begin
    diff    = '0;
    frac_s  = signed'({1'b0, use_frac_q});
    if (ch_q < CH_W'(kla_pkg::CHANNELS)) begin
      diff = signed'({next_q[ch_q][VAL_W-1], next_q[ch_q]})
           - signed'({base_q[ch_q][VAL_W-1], base_q[ch_q]});
    end
    prod_d  = PROD_W'(diff) * PROD_W'(frac_s);
    prod_sh = prod_q >>> FRAC_W;
  end

  // hold one past the last channel once the walk is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (cmd_i.load_item) begin
      ch_q <= '0;
    end else if (cmd_i.mul_step && ch_q != CH_W'(kla_pkg::CHANNELS)) begin
      ch_q <= ch_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      if (ch_q < CH_W'(kla_pkg::CHANNELS)) begin
        prod_q  <= prod_d;
        pbase_q <= base_q[ch_q];
      end
      if (ch_q != '0) begin
        res_q[ch_q - CH_W'(1)] <= pbase_q + prod_sh[VAL_W-1:0];
      end
    end
  end

  // output register
  logic               out_valid_q;
  kla_pkg::out_item_t result_q;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q.val      <= zero_q ? '0 : res_q;
      result_q.segment  <= kla_pkg::SEG_OUT_W'(use_seg_q);
      result_q.fraction <= use_frac_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  assign sts_o.is_tick  = item_q.command == kla_pkg::CMD_TICK;
  assign sts_o.slot_ok  = 32'(item_q.key_slot) < MAX_KEYS;
  assign sts_o.div_done = div_cnt_q == DC_W'(kla_pkg::STEP_W - 1);
  assign sts_o.mul_done = ch_q == CH_W'(kla_pkg::CHANNELS);
  assign sts_o.out_free = out_free;

  // never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output register overwritten");

  // a stored step lies between 1 and one whole segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_write |-> (quo_q != '0 && quo_q <= (kla_pkg::STEP_W'(1) << FRAC_W)))
    else $error("phase step out of range");

  // the channel walk stops one past the last channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q <= CH_W'(kla_pkg::CHANNELS))
    else $error("channel counter overran");

  // a held, cleared or empty-table tick always reports segment zero, fraction zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_item && !adv_d) |=> (use_seg_q == '0 && use_frac_q == '0))
    else $error("held tick not at key zero");

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for keyframe_lerp_animator
// Fills the key table, then runs directed and random key writes and ticks
// through several key_count/run_enable settings. Every returned pose is
// compared field by field with a bit-exact blend computed in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import kla_pkg::*;

  localparam int unsigned NKEYS    = 16;
  localparam int unsigned SETTLE   = 40;
  localparam int unsigned LONG_OFF = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_KEY_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  kla_in_if  in_ch();
  kla_out_if out_ch();

  keyframe_lerp_animator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .item_i(in_ch), .result_o(out_ch)
  );

  always #4 clk_i = ~clk_i;

  // bench copy of the animator state
  logic [CHANNELS-1:0][VAL_W-1:0] pose_table [NKEYS];
  logic [STEP_W-1:0] step_table [NKEYS];
  logic [3:0]        seg_now;
  logic [FRAC_W-1:0] frac_now;
  logic [KC_W-1:0]   keys_cfg;
  logic              run_cfg;

  in_item_t  pending_q [$];
  out_item_t pose_q [$];
  int errors = 0, ticks_sent = 0, writes_sent = 0, poses_checked = 0;
  bit quiet = 1'b0;
  int off_left = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] base,
                                             input logic [VAL_W-1:0] nxt,
                                             input logic [FRAC_W-1:0] frac);
    longint b, n, prod, r;
    b = longint'($signed(base));
    n = longint'($signed(nxt));
    prod = (n - b) * longint'({1'b0, frac});
    r = b + (prod >>> FRAC_W);
    return r[VAL_W-1:0];
  endfunction

  function automatic out_item_t pose_at(input logic [3:0] seg, input logic [FRAC_W-1:0] frac,
                                        input bit blank);
    out_item_t o;
    o.segment = seg;
    o.fraction = frac;
    for (int c = 0; c < CHANNELS; c++) begin
      if (blank) o.val[c] = '0;
      else if (frac == 0 || seg == NKEYS - 1) o.val[c] = pose_table[seg][c];
      else o.val[c] = blend(pose_table[seg][c], pose_table[seg + 1][c], frac);
    end
    return o;
  endfunction

  // advance the bench state by one accepted beat; queue the pose a tick returns
  task automatic animate(input in_item_t it);
    int n;
    logic [STEP_W:0] total;
    if (it.command == CMD_WRITE) begin
      pose_table[it.key_slot] = it.key_val;
      step_table[it.key_slot] = STEP_W'(17'h10000 / (it.key_frames == 0 ? 1 : it.key_frames));
      return;
    end
    n = keys_cfg > NKEYS ? NKEYS : keys_cfg;
    if (n == 0) pose_q.push_back(pose_at(0, 0, 1'b1));
    else if (!run_cfg) pose_q.push_back(pose_at(0, 0, 1'b0));
    else if (n < 2 || seg_now > n - 2) begin
      seg_now = 0;
      frac_now = 0;
      pose_q.push_back(pose_at(0, 0, 1'b0));
    end else begin
      pose_q.push_back(pose_at(seg_now, frac_now, 1'b0));
      total = frac_now + step_table[seg_now];
      frac_now = total[FRAC_W-1:0];
      seg_now = seg_now + total[FRAC_W+1:FRAC_W];
    end
  endtask

  // driver
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t it;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.command = in_ch.command;
        it.key_slot = in_ch.key_slot;
        it.key_val = {in_ch.key_scale_z, in_ch.key_scale_y, in_ch.key_scale_x,
                      in_ch.key_rot_z, in_ch.key_rot_y, in_ch.key_rot_x,
                      in_ch.key_pos_z, in_ch.key_pos_y, in_ch.key_pos_x};
        it.key_frames = in_ch.key_frames;
        animate(it);
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap > 0) begin
          gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.command <= it.command;
          in_ch.key_slot <= it.key_slot;
          in_ch.key_pos_x <= it.key_val[0];
          in_ch.key_pos_y <= it.key_val[1];
          in_ch.key_pos_z <= it.key_val[2];
          in_ch.key_rot_x <= it.key_val[3];
          in_ch.key_rot_y <= it.key_val[4];
          in_ch.key_rot_z <= it.key_val[5];
          in_ch.key_scale_x <= it.key_val[6];
          in_ch.key_scale_y <= it.key_val[7];
          in_ch.key_scale_z <= it.key_val[8];
          in_ch.key_frames <= it.key_frames;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  int stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (off_left > 0) begin
      off_left <= off_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t want;
    logic [CHANNELS-1:0][VAL_W-1:0] got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_scale_z, out_ch.out_scale_y, out_ch.out_scale_x,
             out_ch.out_rot_z, out_ch.out_rot_y, out_ch.out_rot_x,
             out_ch.out_pos_z, out_ch.out_pos_y, out_ch.out_pos_x};
      if (pose_q.size() == 0) begin
        report("unexpected pose", got[0], 0);
      end else begin
        want = pose_q.pop_front();
        poses_checked++;
        for (int c = 0; c < CHANNELS; c++)
          if (got[c] !== want.val[c]) report($sformatf("channel %0d", c), got[c], want.val[c]);
        if (out_ch.segment !== want.segment) report("segment", out_ch.segment, want.segment);
        if (out_ch.fraction !== want.fraction) report("fraction", out_ch.fraction, want.fraction);
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_val();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(VAL_W-1){1'b0}}};
      1: return {1'b0, {(VAL_W-1){1'b1}}};
      2: return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic push_key(input int slot, input logic [FRAME_W-1:0] frames);
    in_item_t it;
    it.command = CMD_WRITE;
    it.key_slot = slot;
    for (int c = 0; c < CHANNELS; c++) it.key_val[c] = pick_val();
    it.key_frames = frames;
    pending_q.push_back(it);
    writes_sent++;
  endtask

  task automatic push_tick();
    in_item_t it;
    it = '0;
    it.command = CMD_TICK;
    it.key_slot = $urandom;
    it.key_frames = $urandom;
    for (int c = 0; c < CHANNELS; c++) it.key_val[c] = $urandom;
    pending_q.push_back(it);
    ticks_sent++;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || pose_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    if (idx == REG_KEY_COUNT) keys_cfg = v;
    else run_cfg = v[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [FRAME_W-1:0] pick_frames();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return FRAME_W'($urandom);
      default: return FRAME_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic run_phase(input int kc, input bit en, input int n);
    set_reg(REG_KEY_COUNT, kc);
    set_reg(REG_RUN_ENABLE, en);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 6) == 0) push_key($urandom_range(0, NKEYS - 1), pick_frames());
      else push_tick();
    drain();
  endtask

  initial begin
    in_item_t it;
    seg_now = 0;
    frac_now = 0;
    keys_cfg = 0;
    run_cfg = 0;
    it = '0;
    in_ch.command = CMD_TICK;
    in_ch.key_slot = '0;
    in_ch.key_pos_x = '0; in_ch.key_pos_y = '0; in_ch.key_pos_z = '0;
    in_ch.key_rot_x = '0; in_ch.key_rot_y = '0; in_ch.key_rot_z = '0;
    in_ch.key_scale_x = '0; in_ch.key_scale_y = '0; in_ch.key_scale_z = '0;
    in_ch.key_frames = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no keys yet: ticks return an all-zero pose whatever the key RAM reads
    push_tick();
    push_tick();
    // fill the table: extreme values, zero and maximum frame counts
    it.command = CMD_WRITE;
    it.key_slot = 0;
    for (int c = 0; c < CHANNELS; c++) it.key_val[c] = {1'b0, {(VAL_W-1){1'b1}}};
    it.key_frames = 2;
    pending_q.push_back(it);
    it.key_slot = 1;
    for (int c = 0; c < CHANNELS; c++) it.key_val[c] = {1'b1, {(VAL_W-1){1'b0}}};
    it.key_frames = 0;
    pending_q.push_back(it);
    writes_sent += 2;
    push_key(2, '1);
    for (int s = 3; s < NKEYS; s++) push_key(s, 3);
    push_tick();
    drain();

    set_reg(REG_KEY_COUNT, 1);
    push_tick();                      // disabled: hold key 0
    drain();
    set_reg(REG_RUN_ENABLE, 1);
    push_tick();                      // single key
    drain();
    set_reg(REG_KEY_COUNT, 2);
    repeat (4) push_tick();           // half step, blend max to min, wrap
    drain();
    set_reg(REG_KEY_COUNT, 3);
    repeat (3) push_tick();
    drain();

    run_phase(16, 1, 200);
    off_left = LONG_OFF;              // hold the output while ticks keep coming
    run_phase(31, 1, 150);
    run_phase(4, 1, 120);
    run_phase(2, 1, 100);
    run_phase(0, 1, 40);
    run_phase(16, 0, 60);
    run_phase(1, 1, 40);
    run_phase($urandom_range(3, 15), 1, 150);
    run_phase(17, 1, 100);
    quiet = 1'b1;
    run_phase(16, 1, 150);

    $display("%0d ticks and %0d key writes sent, %0d poses checked", ticks_sent,
             writes_sent, poses_checked);
    $display("covered empty, disabled, single-key, wrap and oversized key counts");
    if (errors == 0) $display("keyframe_lerp_animator test passed");
    else $display("keyframe_lerp_animator test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("keyframe_lerp_animator test failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/kla_pkg.sv
rtl/core/kla_if.sv
rtl/core/kla_ram.sv
rtl/core/kla_ctrl.sv
rtl/core/kla_datapath.sv
rtl/core/keyframe_lerp_animator.sv
dv/tb.sv
